/* hdl/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants, opcode and status codes, payload structs and the
// controller/datapath command and status structs of the RPN evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int OUT_CNT_W   = 5;
    localparam int DIVD_W      = DATA_W + FRAC_W;
    localparam int DIV_CNT_W   = $clog2(DIVD_W);

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // opcodes
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_DUMP = 3'd5;
    localparam logic [2:0] OP_END  = 3'd6;

    // result status codes
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_FEW  = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_DIV0 = 3'd3;
    localparam logic [2:0] ST_LEFT = 3'd4;
    localparam logic [2:0] ST_SAT  = 3'd5;

    // result register sources
    localparam logic [2:0] RES_ZERO   = 3'd0;
    localparam logic [2:0] RES_PV     = 3'd1;
    localparam logic [2:0] RES_RAM    = 3'd2;
    localparam logic [2:0] RES_ADDSUB = 3'd3;
    localparam logic [2:0] RES_MUL    = 3'd4;
    localparam logic [2:0] RES_DIV    = 3'd5;
    localparam logic [2:0] RES_DIV0   = 3'd6;

    // stack read address selects
    localparam logic [1:0] RD_TOP    = 2'd0;
    localparam logic [1:0] RD_SECOND = 2'd1;
    localparam logic [1:0] RD_START  = 2'd2;
    localparam logic [1:0] RD_NEXT   = 2'd3;

    typedef struct packed {
        logic        [2:0]        opcode;
        logic signed [DATA_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic        [2:0]           status;
        logic signed [DATA_W-1:0]    value;
        logic        [OUT_CNT_W-1:0] stack_count;
        logic                        last;
    } t_out_item;

    typedef struct packed {
        logic       accept;
        logic       ram_re;
        logic [1:0] rd_sel;
        logic       wr_push;
        logic       wr_res;
        logic       depth_sub2;
        logic       depth_clear;
        logic       ld_b;
        logic       ld_a;
        logic       mul_ld;
        logic       div_start;
        logic       res_ld;
        logic [2:0] res_src;
        logic [2:0] res_status;
        logic       idx_init;
        logic       idx_inc;
        logic       out_ld;
        logic       out_from_ram;
        logic       out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] opcode;
        logic       empty;
        logic       few;
        logic       full;
        logic       dump_last;
        logic       b_zero;
        logic       div_done;
        logic       out_free;
    } t_dp_stat;

endpackage

/* hdl/rpn_ram.sv */
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/rpn_div.sv */
// ----------------------------------------------------------------------------
// rpn_div
// Restoring unsigned divider, one quotient bit per cycle over the
// shifted Q16.16 dividend magnitude.
// ----------------------------------------------------------------------------
module rpn_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rpn_pkg::DIVD_W-1:0] i_dividend,
    input  logic [rpn_pkg::DATA_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [rpn_pkg::DIVD_W-1:0] o_quotient
);
    import rpn_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DIVD_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_div;

    logic [DATA_W:0]      w_shift;
    logic [DATA_W:0]      w_diff;
    logic                 w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[DIVD_W-1]};
        w_ge    = w_shift >= {1'b0, r_div};
        w_diff  = w_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // quotient bits shift in as dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DATA_W-1:0] : w_shift[DATA_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hdl/rpn_dp.sv */
// ----------------------------------------------------------------------------
// rpn_dp
// Datapath: operand stack RAM, depth and dump index, operand registers,
// add/sub, multiplier, divider, result register and output register.
// ----------------------------------------------------------------------------
module rpn_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpn_pkg::t_in_item   i_item,
    input  rpn_pkg::t_dp_cmd    i_cmd,
    output rpn_pkg::t_dp_stat   o_stat,
    output logic                o_valid,
    input  logic                i_ready,
    output rpn_pkg::t_out_item  o_item
);
    import rpn_pkg::*;

    logic [2:0]               r_op;
    logic [DATA_W-1:0]        r_pv;
    logic [CNT_W-1:0]         r_depth;
    logic [PTR_W-1:0]         r_idx;
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_b;
    logic signed [2*DATA_W-1:0] r_prod;
    logic [DATA_W-1:0]        r_res;
    logic [2:0]               r_res_status;
    t_out_item                r_out;
    logic                     r_out_valid;

    logic [DATA_W-1:0]        w_rdata;
    logic [PTR_W-1:0]         w_raddr;
    logic [PTR_W-1:0]         w_start;
    logic                     w_we;
    logic [DATA_W-1:0]        w_wdata;

    logic [DATA_W:0]          w_sum;
    logic                     w_sum_sat;
    logic                     w_mul_fit;
    logic [DATA_W-1:0]        w_a_u;
    logic [DATA_W-1:0]        w_b_u;
    logic [DATA_W-1:0]        w_a_mag;
    logic [DATA_W-1:0]        w_b_mag;
    logic                     w_q_neg;
    logic [DIVD_W-1:0]        w_quot;
    logic                     w_div_done;
    logic                     w_div_sat;
    logic [DATA_W-1:0]        w_res_val;
    logic [2:0]               w_res_st;

    // dump starts at the lowest entry that fits in one burst of results
    always_comb begin
        if (int'(r_depth) > MAX_RESULTS) begin
            w_start = PTR_W'(r_depth - CNT_W'(MAX_RESULTS));
        end else begin
            w_start = '0;
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_TOP:    w_raddr = PTR_W'(r_depth - CNT_W'(1));
            RD_SECOND: w_raddr = PTR_W'(r_depth - CNT_W'(2));
            RD_START:  w_raddr = w_start;
            RD_NEXT:   w_raddr = r_idx + 1'b1;
        endcase
    end

    assign w_we    = i_cmd.wr_push | i_cmd.wr_res;
    assign w_wdata = i_cmd.wr_push ? r_pv : r_res;

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (PTR_W'(r_depth)),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // signed magnitudes for the divider
    always_comb begin
        w_a_u   = r_a;
        w_b_u   = r_b;
        w_a_mag = w_a_u[DATA_W-1] ? (~w_a_u + 1'b1) : w_a_u;
        w_b_mag = w_b_u[DATA_W-1] ? (~w_b_u + 1'b1) : w_b_u;
        w_q_neg = w_a_u[DATA_W-1] ^ w_b_u[DATA_W-1];
    end

    rpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({w_a_mag, {FRAC_W{1'b0}}}),
        .i_divisor  (w_b_mag),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        if (r_op == OP_SUB) begin
            w_sum = {r_a[DATA_W-1], r_a} - {r_b[DATA_W-1], r_b};
        end else begin
            w_sum = {r_a[DATA_W-1], r_a} + {r_b[DATA_W-1], r_b};
        end
        w_sum_sat = w_sum[DATA_W] != w_sum[DATA_W-1];
        // product >> 16 fits when the result sign and all bits above it agree
        w_mul_fit = (&r_prod[2*DATA_W-1:DATA_W+FRAC_W-1])
                  | ~(|r_prod[2*DATA_W-1:DATA_W+FRAC_W-1]);
        if (w_q_neg) begin
            w_div_sat = (|w_quot[DIVD_W-1:DATA_W])
                      | (w_quot[DATA_W-1] & (|w_quot[DATA_W-2:0]));
        end else begin
            w_div_sat = |w_quot[DIVD_W-1:DATA_W-1];
        end
    end

    always_comb begin
        w_res_st = i_cmd.res_status;
        unique case (i_cmd.res_src)
            RES_ZERO: begin
                w_res_val = '0;
            end
            RES_PV: begin
                w_res_val = r_pv;
            end
            RES_RAM: begin
                w_res_val = w_rdata;
            end
            RES_ADDSUB: begin
                w_res_st = w_sum_sat ? ST_SAT : ST_OK;
                if (w_sum_sat) begin
                    w_res_val = w_sum[DATA_W] ? SAT_MIN : SAT_MAX;
                end else begin
                    w_res_val = w_sum[DATA_W-1:0];
                end
            end
            RES_MUL: begin
                w_res_st = w_mul_fit ? ST_OK : ST_SAT;
                if (w_mul_fit) begin
                    w_res_val = r_prod[DATA_W+FRAC_W-1:FRAC_W];
                end else begin
                    w_res_val = r_prod[2*DATA_W-1] ? SAT_MIN : SAT_MAX;
                end
            end
            RES_DIV: begin
                w_res_st = w_div_sat ? ST_SAT : ST_OK;
                if (w_div_sat) begin
                    w_res_val = w_q_neg ? SAT_MIN : SAT_MAX;
                end else if (w_q_neg) begin
                    w_res_val = ~w_quot[DATA_W-1:0] + 1'b1;
                end else begin
                    w_res_val = w_quot[DATA_W-1:0];
                end
            end
            RES_DIV0: begin
                if (r_a[DATA_W-1]) begin
                    w_res_val = SAT_MIN;
                end else if (r_a != '0) begin
                    w_res_val = SAT_MAX;
                end else begin
                    w_res_val = '0;
                end
            end
            default: begin
                w_res_val = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            priority if (i_cmd.depth_clear) begin
                r_depth <= '0;
            end else if (i_cmd.depth_sub2) begin
                r_depth <= r_depth - CNT_W'(2);
            end else if (w_we) begin
                r_depth <= r_depth + CNT_W'(1);
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= i_item.opcode;
            r_pv <= i_item.push_value;
        end
        if (i_cmd.idx_init) begin
            r_idx <= w_start;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.ld_b) begin
            r_b <= w_rdata;
        end
        if (i_cmd.ld_a) begin
            r_a <= w_rdata;
        end
        if (i_cmd.mul_ld) begin
            r_prod <= r_a * r_b;
        end
        if (i_cmd.res_ld) begin
            r_res        <= w_res_val;
            r_res_status <= w_res_st;
        end
        if (i_cmd.out_ld) begin
            r_out.status      <= i_cmd.out_from_ram ? ST_OK : r_res_status;
            r_out.value       <= i_cmd.out_from_ram ? w_rdata : r_res;
            r_out.stack_count <= OUT_CNT_W'(r_depth);
            r_out.last        <= i_cmd.out_last;
        end
    end

    always_comb begin
        o_stat.opcode    = r_op;
        o_stat.empty     = r_depth == '0;
        o_stat.few       = r_depth < CNT_W'(2);
        o_stat.full      = r_depth == CNT_W'(STACK_DEPTH);
        o_stat.dump_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_depth;
        o_stat.b_zero    = r_b == '0;
        o_stat.div_done  = w_div_done;
        o_stat.out_free  = !r_out_valid || i_ready;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

/* hdl/rpn_ctrl.sv */
// ----------------------------------------------------------------------------
// rpn_ctrl
// Controller state machine: decodes one token, sequences stack reads,
// the arithmetic units, the write-back and the result transactions.
// ----------------------------------------------------------------------------
module rpn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rpn_pkg::t_dp_stat i_stat,
    output rpn_pkg::t_dp_cmd  o_cmd
);
    import rpn_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_RDTOP    = 4'd2;
    localparam logic [3:0] S_RDB      = 4'd3;
    localparam logic [3:0] S_RDA      = 4'd4;
    localparam logic [3:0] S_EXEC     = 4'd5;
    localparam logic [3:0] S_MULSAT   = 4'd6;
    localparam logic [3:0] S_DIVWAIT  = 4'd7;
    localparam logic [3:0] S_WRITE    = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;
    localparam logic [3:0] S_DUMP     = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.opcode)
                    OP_PUSH: begin
                        if (i_stat.full) begin
                            o_cmd.ram_re = 1'b1;
                            o_cmd.rd_sel = RD_TOP;
                            n_state      = S_RDTOP;
                        end else begin
                            o_cmd.wr_push    = 1'b1;
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_src    = RES_PV;
                            o_cmd.res_status = ST_OK;
                            n_state          = S_EMIT;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (i_stat.empty) begin
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_src    = RES_ZERO;
                            o_cmd.res_status = ST_FEW;
                            n_state          = S_EMIT;
                        end else begin
                            o_cmd.ram_re = 1'b1;
                            o_cmd.rd_sel = RD_TOP;
                            n_state      = i_stat.few ? S_RDTOP : S_RDB;
                        end
                    end
                    OP_DUMP: begin
                        if (i_stat.empty) begin
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_src    = RES_ZERO;
                            o_cmd.res_status = ST_OK;
                            n_state          = S_EMIT;
                        end else begin
                            o_cmd.idx_init = 1'b1;
                            o_cmd.ram_re   = 1'b1;
                            o_cmd.rd_sel   = RD_START;
                            n_state        = S_DUMP;
                        end
                    end
                    OP_END: begin
                        if (i_stat.empty) begin
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_src    = RES_ZERO;
                            o_cmd.res_status = ST_OK;
                            n_state          = S_EMIT;
                        end else begin
                            o_cmd.ram_re = 1'b1;
                            o_cmd.rd_sel = RD_TOP;
                            n_state      = S_RDTOP;
                        end
                    end
                    default: begin
                        // unused opcode: no transaction
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RDTOP: begin
                o_cmd.res_ld  = 1'b1;
                o_cmd.res_src = RES_RAM;
                unique case (i_stat.opcode)
                    OP_PUSH: begin
                        o_cmd.res_status = ST_FULL;
                    end
                    OP_END: begin
                        o_cmd.res_status  = i_stat.few ? ST_OK : ST_LEFT;
                        o_cmd.depth_clear = 1'b1;
                    end
                    default: begin
                        o_cmd.res_status = ST_FEW;
                    end
                endcase
                n_state = S_EMIT;
            end
            S_RDB: begin
                o_cmd.ld_b   = 1'b1;
                o_cmd.ram_re = 1'b1;
                o_cmd.rd_sel = RD_SECOND;
                n_state      = S_RDA;
            end
            S_RDA: begin
                o_cmd.ld_a       = 1'b1;
                o_cmd.depth_sub2 = 1'b1;
                n_state          = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_stat.opcode)
                    OP_MUL: begin
                        o_cmd.mul_ld = 1'b1;
                        n_state      = S_MULSAT;
                    end
                    OP_DIV: begin
                        if (i_stat.b_zero) begin
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_src    = RES_DIV0;
                            o_cmd.res_status = ST_DIV0;
                            n_state          = S_WRITE;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIVWAIT;
                        end
                    end
                    default: begin
                        o_cmd.res_ld  = 1'b1;
                        o_cmd.res_src = RES_ADDSUB;
                        n_state       = S_WRITE;
                    end
                endcase
            end
            S_MULSAT: begin
                o_cmd.res_ld  = 1'b1;
                o_cmd.res_src = RES_MUL;
                n_state       = S_WRITE;
            end
            S_DIVWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_src = RES_DIV;
                    n_state       = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.wr_res = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld       = 1'b1;
                    o_cmd.out_from_ram = 1'b1;
                    o_cmd.out_last     = i_stat.dump_last;
                    if (i_stat.dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch the next entry while this one is taken
                        o_cmd.idx_inc = 1'b1;
                        o_cmd.ram_re  = 1'b1;
                        o_cmd.rd_sel  = RD_NEXT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/rpn_stack_evaluator.sv */
// Divide runs through the 48-step divider.
// Dump: one entry per cycle while taken.
// One token at a time: the next is taken once all results of this one are loaded.
// Synchronous active-low reset empties the stack and drops any pending result.
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse Polish evaluator over a bounded stack of signed Q16.16 values.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rpn_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output rpn_pkg::t_out_item o_item
);
    import rpn_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rpn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    rpn_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule

/* hdl/rpn_checker.sv */
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks of the RPN evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module rpn_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input rpn_pkg::t_out_item o_item
);
    import rpn_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");

    // no new token while a dump is still in flight
    a_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.last |-> !o_ready)
        else $error("token accepted in the middle of a dump");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == ST_FULL |->
            o_item.stack_count == OUT_CNT_W'(STACK_DEPTH) && o_item.last)
        else $error("stack full reported with wrong count");

    a_few_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == ST_FEW |->
            o_item.stack_count < OUT_CNT_W'(2) && o_item.last)
        else $error("too few operands reported with two or more entries");

    a_end_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == ST_LEFT |-> o_item.stack_count == '0)
        else $error("stack not emptied after end");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);
